/* hw/rtl/sparc_instruction_decoder_assert.svh */
// Assertion macros for the instruction decoder.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef SPARC_INSTRUCTION_DECODER_ASSERT_SVH
`define SPARC_INSTRUCTION_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define SID_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed in the same cycle");

`define SID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed one cycle later");

`else

`define SID_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define SID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/sid_pkg.sv */
package sid_pkg;

    localparam int WORD_W = 32;

    localparam logic [1:0] OP_FMT2  = 2'd0;
    localparam logic [1:0] OP_CALL  = 2'd1;
    localparam logic [1:0] OP_ARITH = 2'd2;
    localparam logic [1:0] OP_MEM   = 2'd3;

    localparam logic [2:0] OP2_UNIMP = 3'd0;
    localparam logic [2:0] OP2_BICC  = 3'd2;
    localparam logic [2:0] OP2_SETHI = 3'd4;
    localparam logic [2:0] OP2_FBFCC = 3'd6;
    localparam logic [2:0] OP2_CBCCC = 3'd7;

    localparam logic [5:0] OP3_ALU_LAST   = 6'd36;
    localparam logic [5:0] OP3_SHIFT_LAST = 6'd39;
    localparam logic [5:0] OP3_RDY        = 6'd40;
    localparam logic [5:0] OP3_RDPSR      = 6'd41;
    localparam logic [5:0] OP3_RDTBR      = 6'd43;
    localparam logic [5:0] OP3_WRY        = 6'd48;
    localparam logic [5:0] OP3_WRPSR      = 6'd49;
    localparam logic [5:0] OP3_WRTBR      = 6'd51;
    localparam logic [5:0] OP3_FPOP1      = 6'd52;
    localparam logic [5:0] OP3_FPOP2      = 6'd53;
    localparam logic [5:0] OP3_CPOP1      = 6'd54;
    localparam logic [5:0] OP3_CPOP2      = 6'd55;
    localparam logic [5:0] OP3_JMPL       = 6'd56;
    localparam logic [5:0] OP3_RETT       = 6'd57;
    localparam logic [5:0] OP3_TICC       = 6'd58;
    localparam logic [5:0] OP3_FLUSH      = 6'd59;
    localparam logic [5:0] OP3_SAVE       = 6'd60;
    localparam logic [5:0] OP3_RESTORE    = 6'd61;

    localparam logic [63:0] OP3_ALU_EMPTY_MASK = 64'h0000_0000_2200_2200;
    localparam logic [63:0] OP3_LD_MASK        = 64'h0000_0000_A60F_A60F;
    localparam logic [63:0] OP3_ST_MASK        = 64'h0000_0000_00F0_00F0;
    localparam logic [63:0] OP3_STFC_MASK      = 64'h00F0_00F0_0000_0000;
    localparam logic [63:0] OP3_LDFC_MASK      = 64'h000B_000B_0000_0000;

    localparam logic [5:0] MN_SR_PSR = 6'd32;
    localparam logic [5:0] MN_CPOP1  = 6'd0;
    localparam logic [5:0] MN_CPOP2  = 6'd1;

    localparam logic [4:0] CLS_UNIMP   = 5'd0;
    localparam logic [4:0] CLS_NOP     = 5'd1;
    localparam logic [4:0] CLS_SETHI   = 5'd2;
    localparam logic [4:0] CLS_BICC    = 5'd3;
    localparam logic [4:0] CLS_FBFCC   = 5'd4;
    localparam logic [4:0] CLS_CBCCC   = 5'd5;
    localparam logic [4:0] CLS_CALL    = 5'd6;
    localparam logic [4:0] CLS_ALU     = 5'd7;
    localparam logic [4:0] CLS_SHIFT   = 5'd8;
    localparam logic [4:0] CLS_RDSR    = 5'd9;
    localparam logic [4:0] CLS_WRSR    = 5'd10;
    localparam logic [4:0] CLS_FPOP    = 5'd11;
    localparam logic [4:0] CLS_CPOP    = 5'd12;
    localparam logic [4:0] CLS_JMPL    = 5'd13;
    localparam logic [4:0] CLS_RETT    = 5'd14;
    localparam logic [4:0] CLS_TRAP    = 5'd15;
    localparam logic [4:0] CLS_FLUSH   = 5'd16;
    localparam logic [4:0] CLS_SAVE    = 5'd17;
    localparam logic [4:0] CLS_RESTORE = 5'd18;
    localparam logic [4:0] CLS_LD      = 5'd19;
    localparam logic [4:0] CLS_ST      = 5'd20;
    localparam logic [4:0] CLS_LDFC    = 5'd21;
    localparam logic [4:0] CLS_STFC    = 5'd22;

    localparam int FP_TABLE_LEN = 38;

    localparam logic [8:0] FP_OPF_TABLE [FP_TABLE_LEN] = '{
        9'd196, 9'd200, 9'd204, 9'd209, 9'd210, 9'd211, 9'd201, 9'd205, 9'd198, 9'd206,
        9'd199, 9'd203, 9'd1,   9'd5,   9'd9,   9'd41,  9'd42,  9'd43,  9'd65,  9'd66,
        9'd67,  9'd69,  9'd70,  9'd71,  9'd73,  9'd74,  9'd75,  9'd105, 9'd110, 9'd77,
        9'd78,  9'd79,  9'd81,  9'd82,  9'd83,  9'd85,  9'd86,  9'd87
    };

    typedef struct packed {
        logic       hit;
        logic [5:0] index;
    } fp_match_t;

    typedef struct packed {
        logic [4:0]        insn_class;
        logic [5:0]        mnemonic_code;
        logic [4:0]        dest_reg;
        logic [4:0]        src1_reg;
        logic [4:0]        src2_reg;
        logic              uses_immediate;
        logic [WORD_W-1:0] immediate_value;
        logic [WORD_W-1:0] target_address;
        logic              annul_bit;
        logic [7:0]        space_id;
        logic [8:0]        sub_opcode;
        logic              recognized;
    } sid_result_t;

    // The table holds no duplicates; scanning downward leaves the lowest matching index.
    function automatic fp_match_t fp_lookup(input logic [8:0] opf);
        fp_match_t m;
        m = '0;
        for (int k = FP_TABLE_LEN - 1; k >= 0; k--)
        begin
            if (FP_OPF_TABLE[k] == opf)
            begin
                m.hit   = 1'b1;
                m.index = 6'(k);
            end
        end
        return m;
    endfunction

endpackage

/* hw/rtl/sid_in_if.sv */
interface sid_in_if import sid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] instr_word;
    logic [WORD_W-1:0] pc;

    modport source (output valid, output instr_word, output pc, input ready);
    modport sink (input valid, input instr_word, input pc, output ready);
endinterface

/* hw/rtl/sid_out_if.sv */
interface sid_out_if import sid_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [4:0]        insn_class;
    logic [5:0]        mnemonic_code;
    logic [4:0]        dest_reg;
    logic [4:0]        src1_reg;
    logic [4:0]        src2_reg;
    logic              uses_immediate;
    logic [WORD_W-1:0] immediate_value;
    logic [WORD_W-1:0] target_address;
    logic              annul_bit;
    logic [7:0]        space_id;
    logic [8:0]        sub_opcode;
    logic              recognized;

    modport source (output valid, output insn_class, output mnemonic_code, output dest_reg,
                    output src1_reg, output src2_reg, output uses_immediate,
                    output immediate_value, output target_address, output annul_bit,
                    output space_id, output sub_opcode, output recognized, input ready);
    modport sink (input valid, input insn_class, input mnemonic_code, input dest_reg,
                  input src1_reg, input src2_reg, input uses_immediate,
                  input immediate_value, input target_address, input annul_bit,
                  input space_id, input sub_opcode, input recognized, output ready);
endinterface

/* hw/rtl/sid_decode.sv */
module sid_decode import sid_pkg::*;
(
    input  logic [WORD_W-1:0] instr_word,
    input  logic [WORD_W-1:0] pc,
    input  logic              byte_swap,
    output sid_result_t       result
);

    logic [WORD_W-1:0] w;
    logic [1:0]        op;
    logic [2:0]        op2;
    logic [5:0]        op3;
    logic [4:0]        frd;
    logic [4:0]        frs1;
    logic [4:0]        frs2;
    logic              fi;
    logic [8:0]        opf;
    logic [WORD_W-1:0] const22;
    logic [WORD_W-1:0] simm13;
    logic [WORD_W-1:0] disp22;
    logic              fmt3;
    logic              opnd;
    logic              three_operand;
    fp_match_t         fp;
    sid_result_t       res;

    always_comb
    begin
        w = byte_swap ? {instr_word[7:0], instr_word[15:8], instr_word[23:16],
                         instr_word[31:24]} : instr_word;
        op      = w[31:30];
        op2     = w[24:22];
        op3     = w[24:19];
        frd     = w[29:25];
        frs1    = w[18:14];
        frs2    = w[4:0];
        fi      = w[13];
        opf     = w[13:5];
        const22 = {10'd0, w[21:0]};
        simm13  = {{19{w[12]}}, w[12:0]};
        disp22  = {{8{w[21]}}, w[21:0], 2'b00};
        fp      = fp_lookup(opf);
        three_operand = (op3 == OP3_FPOP1) && ((opf inside {[9'd65:9'd79]}) ||
                        opf == 9'd105 || opf == 9'd110);
        fmt3 = 1'b0;
        opnd = 1'b0;
        res  = '0;

        case (op)
            OP_FMT2:
            begin
                if (op2 == OP2_BICC || op2 == OP2_FBFCC || op2 == OP2_CBCCC)
                begin
                    if (op2 == OP2_BICC)
                        res.insn_class = CLS_BICC;
                    else if (op2 == OP2_FBFCC)
                        res.insn_class = CLS_FBFCC;
                    else
                        res.insn_class = CLS_CBCCC;
                    res.mnemonic_code  = {2'b00, w[28:25]};
                    res.annul_bit      = w[29];
                    res.target_address = pc + disp22;
                    res.recognized     = 1'b1;
                end
                else if (op2 == OP2_SETHI)
                begin
                    res.recognized = 1'b1;
                    if (frd == 5'd0 && w[21:0] == 22'd0)
                        res.insn_class = CLS_NOP;
                    else
                    begin
                        res.insn_class      = CLS_SETHI;
                        res.dest_reg        = frd;
                        res.immediate_value = {w[21:0], 10'd0};
                    end
                end
                else
                begin
                    res.insn_class      = CLS_UNIMP;
                    res.immediate_value = const22;
                    res.recognized      = (op2 == OP2_UNIMP);
                end
            end
            OP_CALL:
            begin
                res.insn_class     = CLS_CALL;
                res.target_address = pc + {w[29:0], 2'b00};
                res.recognized     = 1'b1;
            end
            OP_ARITH:
            begin
                fmt3 = 1'b1;
                res.recognized    = 1'b1;
                res.mnemonic_code = op3;
                if (op3 <= OP3_ALU_LAST)
                begin
                    res.insn_class = CLS_ALU;
                    opnd = 1'b1;
                    if (OP3_ALU_EMPTY_MASK[op3])
                        res.recognized = 1'b0;
                end
                else if (op3 <= OP3_SHIFT_LAST)
                begin
                    res.insn_class = CLS_SHIFT;
                    opnd = 1'b1;
                end
                else if (op3 <= OP3_RDTBR)
                begin
                    res.insn_class    = CLS_RDSR;
                    res.mnemonic_code = (op3 == OP3_RDY) ? {1'b0, frs1}
                                        : op3 - OP3_RDPSR + MN_SR_PSR;
                end
                else if (op3 inside {[OP3_WRY:OP3_WRTBR]})
                begin
                    res.insn_class    = CLS_WRSR;
                    opnd = 1'b1;
                    res.mnemonic_code = (op3 == OP3_WRY) ? {1'b0, frd}
                                        : op3 - OP3_WRPSR + MN_SR_PSR;
                end
                else if (op3 == OP3_FPOP1 || op3 == OP3_FPOP2)
                begin
                    res.insn_class    = CLS_FPOP;
                    res.sub_opcode    = opf;
                    res.mnemonic_code = fp.hit ? fp.index : 6'd0;
                    res.recognized    = fp.hit;
                end
                else if (op3 == OP3_CPOP1 || op3 == OP3_CPOP2)
                begin
                    res.insn_class    = CLS_CPOP;
                    res.mnemonic_code = (op3 == OP3_CPOP2) ? MN_CPOP2 : MN_CPOP1;
                    res.sub_opcode    = opf;
                end
                else if (op3 == OP3_JMPL)
                begin
                    res.insn_class = CLS_JMPL;
                    opnd = 1'b1;
                end
                else if (op3 == OP3_RETT)
                begin
                    res.insn_class = CLS_RETT;
                    opnd = 1'b1;
                end
                else if (op3 == OP3_TICC)
                begin
                    res.insn_class    = CLS_TRAP;
                    res.mnemonic_code = {2'b00, w[28:25]};
                    opnd = 1'b1;
                end
                else if (op3 == OP3_FLUSH)
                begin
                    res.insn_class = CLS_FLUSH;
                    opnd = 1'b1;
                end
                else if (op3 == OP3_SAVE)
                begin
                    res.insn_class = CLS_SAVE;
                    opnd = 1'b1;
                end
                else if (op3 == OP3_RESTORE)
                begin
                    res.insn_class = CLS_RESTORE;
                    opnd = 1'b1;
                end
                else
                begin
                    fmt3 = 1'b0;
                    res.insn_class      = CLS_UNIMP;
                    res.mnemonic_code   = 6'd0;
                    res.recognized      = 1'b0;
                    res.immediate_value = const22;
                end
            end
            default:
            begin
                fmt3 = 1'b1;
                opnd = 1'b1;
                res.recognized    = 1'b1;
                res.mnemonic_code = op3;
                if (OP3_LD_MASK[op3])
                    res.insn_class = CLS_LD;
                else if (OP3_ST_MASK[op3])
                    res.insn_class = CLS_ST;
                else if (OP3_STFC_MASK[op3])
                    res.insn_class = CLS_STFC;
                else if (OP3_LDFC_MASK[op3])
                    res.insn_class = CLS_LDFC;
                else
                begin
                    fmt3 = 1'b0;
                    opnd = 1'b0;
                    res.insn_class      = CLS_UNIMP;
                    res.mnemonic_code   = 6'd0;
                    res.recognized      = 1'b0;
                    res.immediate_value = const22;
                end
                if ((OP3_LD_MASK[op3] || OP3_ST_MASK[op3]) && op3[4] && !fi)
                    res.space_id = w[12:5];
            end
        endcase

        if (fmt3)
        begin
            res.dest_reg = frd;
            res.src1_reg = (res.insn_class == CLS_FPOP && !three_operand) ? 5'd0 : frs1;
            res.src2_reg = frs2;
        end
        if (opnd)
        begin
            res.uses_immediate = fi;
            if (fi)
                res.immediate_value = (res.insn_class == CLS_TRAP) ? {25'd0, w[6:0]} : simm13;
        end
    end

    assign result = res;

endmodule

/* hw/rtl/sparc_instruction_decoder.sv */
// Channel   Direction  Contents
// instr     in         instr_word, pc
// result    out        decoded fields of one instruction
// cfg       in         byte_swap write (cfg_we, cfg_wdata)
//
// Each word passes through an input register, then the decode logic and the result register.
// One word is accepted in every cycle while result.ready holds.
// Reset clears both valid flags and byte_swap. A stalled result holds the result register and
// the input register keeps taking one more word behind it before instr.ready drops.
module sparc_instruction_decoder import sid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    sid_in_if.sink    instr,
    sid_out_if.source result
);

    `include "sparc_instruction_decoder_assert.svh"

    logic              byte_swap_reg;
    logic              byte_swap_next;
    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic [WORD_W-1:0] stage_word_reg;
    logic [WORD_W-1:0] stage_pc_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    sid_result_t       result_reg;
    sid_result_t       decoded;
    logic              stage_load;
    logic              result_load;

    sid_decode u_decode
    (
        .instr_word (stage_word_reg),
        .pc         (stage_pc_reg),
        .byte_swap  (byte_swap_reg),
        .result     (decoded)
    );

    assign result_load = stage_valid_reg && (!result_valid_reg || result.ready);
    assign instr.ready = !stage_valid_reg || result_load;
    assign stage_load  = instr.valid && instr.ready;

    always_comb
    begin
        byte_swap_next    = cfg_we ? cfg_wdata : byte_swap_reg;
        stage_valid_next  = stage_load ? 1'b1 : (result_load ? 1'b0 : stage_valid_reg);
        result_valid_next = result_load ? 1'b1 : (result.ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_swap_reg    <= 1'b0;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_swap_reg    <= byte_swap_next;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            stage_word_reg <= instr.instr_word;
            stage_pc_reg   <= instr.pc;
        end
        if (result_load)
            result_reg <= decoded;
    end

    assign result.valid           = result_valid_reg;
    assign result.insn_class      = result_reg.insn_class;
    assign result.mnemonic_code   = result_reg.mnemonic_code;
    assign result.dest_reg        = result_reg.dest_reg;
    assign result.src1_reg        = result_reg.src1_reg;
    assign result.src2_reg        = result_reg.src2_reg;
    assign result.uses_immediate  = result_reg.uses_immediate;
    assign result.immediate_value = result_reg.immediate_value;
    assign result.target_address  = result_reg.target_address;
    assign result.annul_bit       = result_reg.annul_bit;
    assign result.space_id        = result_reg.space_id;
    assign result.sub_opcode      = result_reg.sub_opcode;
    assign result.recognized      = result_reg.recognized;

    `SID_ASSERT_NEXT(a_load_gives_result, clk, rst_n, result_load, result_valid_reg)
    `SID_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !instr.ready,
        stage_valid_reg && result_valid_reg && !result.ready)
    `SID_ASSERT_SAME(a_nop_is_clean, clk, rst_n,
        result_valid_reg && result_reg.insn_class == CLS_NOP,
        result_reg.recognized && result_reg.dest_reg == 5'd0 &&
        result_reg.immediate_value == '0)
    `SID_ASSERT_SAME(a_control_transfer_known, clk, rst_n,
        result_valid_reg && (result_reg.insn_class == CLS_BICC ||
        result_reg.insn_class == CLS_FBFCC || result_reg.insn_class == CLS_CBCCC ||
        result_reg.insn_class == CLS_CALL), result_reg.recognized)

endmodule

/* verif/sparc_instruction_decoder_tb.sv */
`timescale 1ns / 1ps

module sparc_instruction_decoder_tb import sid_pkg::*;;

    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int DRAIN_CAP     = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 150;

    localparam logic [2:0] OP2_SPARE       = 3'd5;
    localparam logic [5:0] OP3_ADD         = 6'd0;
    localparam logic [5:0] OP3_ALU_HOLE    = 6'd29;
    localparam logic [5:0] OP3_ARITH_SPARE = 6'd63;
    localparam logic [5:0] OP3_LDA         = 6'd16;
    localparam logic [5:0] OP3_STA         = 6'd20;
    localparam logic [5:0] OP3_LDF         = 6'd32;
    localparam logic [5:0] OP3_MEM_SPARE   = 6'd8;
    localparam logic [4:0] RS1_STBAR       = 5'd15;
    localparam logic [8:0] OPF_3OP_LO      = 9'd65;
    localparam logic [8:0] OPF_3OP_HI      = 9'd79;
    localparam logic [8:0] OPF_3OP_X       = 9'd105;
    localparam logic [8:0] OPF_3OP_Y       = 9'd110;
    localparam logic [8:0] OPF_UNLISTED    = 9'h1FF;

    localparam int FPOP_OPF_LEN = 38;
    localparam logic [8:0] FPOP_OPF [FPOP_OPF_LEN] = '{
        9'd196, 9'd200, 9'd204, 9'd209, 9'd210, 9'd211, 9'd201, 9'd205, 9'd198, 9'd206,
        9'd199, 9'd203, 9'd1,   9'd5,   9'd9,   9'd41,  9'd42,  9'd43,  9'd65,  9'd66,
        9'd67,  9'd69,  9'd70,  9'd71,  9'd73,  9'd74,  9'd75,  9'd105, 9'd110, 9'd77,
        9'd78,  9'd79,  9'd81,  9'd82,  9'd83,  9'd85,  9'd86,  9'd87
    };

    class decode_scoreboard;
        sid_result_t expected_q[$];
        logic        byte_swap;
        int          errors;
        int          checked;

        function new();
            byte_swap = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function sid_result_t decode_word(input logic [31:0] raw, input logic [31:0] pc,
                                          input logic swap);
            sid_result_t r;
            logic [31:0] w;
            logic [1:0]  op;
            logic [2:0]  op2;
            logic [5:0]  op3;
            logic [4:0]  frd;
            logic [4:0]  frs1;
            logic [8:0]  opf;
            logic        fi;
            logic        opnd;
            logic        fmt3;
            int          k;
            r    = '0;
            opnd = 1'b0;
            fmt3 = 1'b0;
            w    = swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
            op   = w[31:30];
            op2  = w[24:22];
            op3  = w[24:19];
            frd  = w[29:25];
            frs1 = w[18:14];
            fi   = w[13];
            opf  = w[13:5];
            case (op)
                OP_FMT2:
                begin
                    if (op2 == OP2_BICC || op2 == OP2_FBFCC || op2 == OP2_CBCCC)
                    begin
                        r.insn_class     = (op2 == OP2_BICC) ? CLS_BICC :
                                           (op2 == OP2_FBFCC) ? CLS_FBFCC : CLS_CBCCC;
                        r.mnemonic_code  = {2'b00, frd[3:0]};
                        r.annul_bit      = w[29];
                        r.target_address = pc + {{8{w[21]}}, w[21:0], 2'b00};
                        r.recognized     = 1'b1;
                    end
                    else if (op2 == OP2_SETHI)
                    begin
                        r.recognized = 1'b1;
                        if (frd == 5'd0 && w[21:0] == 22'd0)
                            r.insn_class = CLS_NOP;
                        else
                        begin
                            r.insn_class      = CLS_SETHI;
                            r.dest_reg        = frd;
                            r.immediate_value = {w[21:0], 10'd0};
                        end
                    end
                    else
                    begin
                        r.insn_class      = CLS_UNIMP;
                        r.immediate_value = {10'd0, w[21:0]};
                        r.recognized      = (op2 == OP2_UNIMP);
                    end
                end
                OP_CALL:
                begin
                    r.insn_class     = CLS_CALL;
                    r.target_address = pc + {w[29:0], 2'b00};
                    r.recognized     = 1'b1;
                end
                OP_ARITH:
                begin
                    fmt3            = 1'b1;
                    r.recognized    = 1'b1;
                    r.mnemonic_code = op3;
                    if (op3 <= OP3_ALU_LAST)
                    begin
                        r.insn_class = CLS_ALU;
                        opnd         = 1'b1;
                        r.recognized = !OP3_ALU_EMPTY_MASK[op3];
                    end
                    else if (op3 <= OP3_SHIFT_LAST)
                    begin
                        r.insn_class = CLS_SHIFT;
                        opnd         = 1'b1;
                    end
                    else if (op3 <= OP3_RDTBR)
                    begin
                        r.insn_class    = CLS_RDSR;
                        r.mnemonic_code = (op3 == OP3_RDY) ? {1'b0, frs1} :
                                          op3 - OP3_RDPSR + MN_SR_PSR;
                    end
                    else if (op3 >= OP3_WRY && op3 <= OP3_WRTBR)
                    begin
                        r.insn_class    = CLS_WRSR;
                        opnd            = 1'b1;
                        r.mnemonic_code = (op3 == OP3_WRY) ? {1'b0, frd} :
                                          op3 - OP3_WRPSR + MN_SR_PSR;
                    end
                    else if (op3 == OP3_FPOP1 || op3 == OP3_FPOP2)
                    begin
                        r.insn_class    = CLS_FPOP;
                        r.sub_opcode    = opf;
                        r.mnemonic_code = '0;
                        r.recognized    = 1'b0;
                        for (k = 0; k < FPOP_OPF_LEN; k++)
                        begin
                            if (!r.recognized && FPOP_OPF[k] == opf)
                            begin
                                r.mnemonic_code = 6'(k);
                                r.recognized    = 1'b1;
                            end
                        end
                    end
                    else if (op3 == OP3_CPOP1 || op3 == OP3_CPOP2)
                    begin
                        r.insn_class    = CLS_CPOP;
                        r.mnemonic_code = (op3 == OP3_CPOP1) ? MN_CPOP1 : MN_CPOP2;
                        r.sub_opcode    = opf;
                    end
                    else if (op3 == OP3_JMPL)
                    begin
                        r.insn_class = CLS_JMPL;
                        opnd         = 1'b1;
                    end
                    else if (op3 == OP3_RETT)
                    begin
                        r.insn_class = CLS_RETT;
                        opnd         = 1'b1;
                    end
                    else if (op3 == OP3_TICC)
                    begin
                        r.insn_class    = CLS_TRAP;
                        opnd            = 1'b1;
                        r.mnemonic_code = {2'b00, frd[3:0]};
                    end
                    else if (op3 == OP3_FLUSH)
                    begin
                        r.insn_class = CLS_FLUSH;
                        opnd         = 1'b1;
                    end
                    else if (op3 == OP3_SAVE)
                    begin
                        r.insn_class = CLS_SAVE;
                        opnd         = 1'b1;
                    end
                    else if (op3 == OP3_RESTORE)
                    begin
                        r.insn_class = CLS_RESTORE;
                        opnd         = 1'b1;
                    end
                    else
                    begin
                        fmt3         = 1'b0;
                        r.recognized = 1'b0;
                    end
                end
                default:
                begin
                    fmt3            = 1'b1;
                    opnd            = 1'b1;
                    r.recognized    = 1'b1;
                    r.mnemonic_code = op3;
                    if (OP3_LD_MASK[op3])
                        r.insn_class = CLS_LD;
                    else if (OP3_ST_MASK[op3])
                        r.insn_class = CLS_ST;
                    else if (OP3_STFC_MASK[op3])
                        r.insn_class = CLS_STFC;
                    else if (OP3_LDFC_MASK[op3])
                        r.insn_class = CLS_LDFC;
                    else
                    begin
                        fmt3         = 1'b0;
                        opnd         = 1'b0;
                        r.recognized = 1'b0;
                    end
                    if ((r.insn_class == CLS_LD || r.insn_class == CLS_ST) && op3[4] && !fi)
                        r.space_id = w[12:5];
                end
            endcase
            if (!fmt3 && op[1])
            begin
                r.insn_class      = CLS_UNIMP;
                r.mnemonic_code   = '0;
                r.immediate_value = {10'd0, w[21:0]};
            end
            if (fmt3)
            begin
                r.dest_reg = frd;
                r.src1_reg = frs1;
                r.src2_reg = w[4:0];
                if (r.insn_class == CLS_FPOP &&
                    !(op3 == OP3_FPOP1 && ((opf >= OPF_3OP_LO && opf <= OPF_3OP_HI) ||
                                           opf == OPF_3OP_X || opf == OPF_3OP_Y)))
                    r.src1_reg = '0;
            end
            if (opnd)
            begin
                r.uses_immediate = fi;
                if (fi)
                    r.immediate_value = (r.insn_class == CLS_TRAP) ? {25'd0, w[6:0]} :
                                        {{19{w[12]}}, w[12:0]};
            end
            return r;
        endfunction

        function void note_word(input logic [31:0] word, input logic [31:0] pc);
            expected_q.push_back(decode_word(word, pc, byte_swap));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input sid_result_t got);
            sid_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: decoded word arrived with none expected, class 0x%0h",
                         $time, got.insn_class);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            compare_field("insn_class", 32'(exp_r.insn_class), 32'(got.insn_class));
            compare_field("mnemonic_code", 32'(exp_r.mnemonic_code),
                          32'(got.mnemonic_code));
            compare_field("dest_reg", 32'(exp_r.dest_reg), 32'(got.dest_reg));
            compare_field("src1_reg", 32'(exp_r.src1_reg), 32'(got.src1_reg));
            compare_field("src2_reg", 32'(exp_r.src2_reg), 32'(got.src2_reg));
            compare_field("uses_immediate", 32'(exp_r.uses_immediate),
                          32'(got.uses_immediate));
            compare_field("immediate_value", exp_r.immediate_value, got.immediate_value);
            compare_field("target_address", exp_r.target_address, got.target_address);
            compare_field("annul_bit", 32'(exp_r.annul_bit), 32'(got.annul_bit));
            compare_field("space_id", 32'(exp_r.space_id), 32'(got.space_id));
            compare_field("sub_opcode", 32'(exp_r.sub_opcode), 32'(got.sub_opcode));
            compare_field("recognized", 32'(exp_r.recognized), 32'(got.recognized));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   rx_stall_pct;
    bit   long_hold_req;

    decode_scoreboard sb;

    sid_in_if  instr_ch ();
    sid_out_if result_ch ();

    sparc_instruction_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .instr     (instr_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] as_sent(input logic [31:0] w);
        return sb.byte_swap ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    endfunction

    function automatic logic [31:0] mk_fmt2(input logic [4:0] rd, input logic [2:0] op2,
                                            input logic [21:0] imm22);
        return {OP_FMT2, rd, op2, imm22};
    endfunction

    function automatic logic [31:0] mk_fmt3(input logic [1:0] op, input logic [4:0] rd,
                                            input logic [5:0] op3, input logic [4:0] rs1,
                                            input logic [13:0] tail);
        return {op, rd, op3, rs1, tail};
    endfunction

    function automatic logic [31:0] gen_word();
        logic [31:0] w;
        int          pick;
        w    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            w[31:30] = OP_ARITH;
            w[24:19] = $urandom_range(0, 1) ? OP3_FPOP1 : OP3_FPOP2;
            if ($urandom_range(0, 3) != 0)
                w[13:5] = FPOP_OPF[$urandom_range(0, FPOP_OPF_LEN - 1)];
        end
        else if (pick < 22)
        begin
            w[31:30] = OP_FMT2;
            w[24:22] = OP2_SETHI;
            w[29:25] = 5'd0;
            if ($urandom_range(0, 1))
                w[21:0] = 22'd0;
        end
        else if (pick < 35)
        begin
            w[31:30] = OP_MEM;
            w[23]    = 1'b1;
            w[13]    = 1'b0;
        end
        else if (pick < 45)
        begin
            w[31:30] = OP_ARITH;
            w[24:19] = 6'($urandom_range(OP3_RDY, OP3_RESTORE));
        end
        return w;
    endfunction

    task automatic send_word(input logic [31:0] w, input logic [31:0] pc);
        @(negedge clk);
        instr_ch.valid      = 1'b1;
        instr_ch.instr_word = w;
        instr_ch.pc         = pc;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        sb.note_word(w, pc);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        instr_ch.valid      = 1'b0;
        instr_ch.instr_word = $urandom();
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        instr_ch.valid = 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_CAP)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_swap(input logic value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.byte_swap = value;
    endtask

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        logic [31:0] pc_v;
        int          pc_pick;
        int          n;
        rx_stall_pct = rx_pct;
        for (n = 0; n < count; n++)
        begin
            pc_pick = $urandom_range(0, 9);
            pc_v    = (pc_pick == 0) ? 32'h0 : (pc_pick == 1) ? 32'hFFFF_FFFF : $urandom();
            send_word(as_sent(gen_word()), pc_v);
            if ($urandom_range(0, 99) < tx_pct)
                pause_sender(pick_gap());
        end
    endtask

    task automatic run_directed();
        rx_stall_pct = 0;
        send_word(mk_fmt2(5'd0, OP2_SETHI, 22'd0), $urandom());
        send_word(mk_fmt2(5'd31, OP2_SETHI, 22'h3FFFFF), $urandom());
        send_word(mk_fmt2(5'd0, OP2_SETHI, 22'd1), $urandom());
        send_word(mk_fmt2(5'd31, OP2_UNIMP, 22'h3FFFFF), $urandom());
        send_word(mk_fmt2(5'd1, OP2_SPARE, 22'h2AAAAA), $urandom());
        send_word(mk_fmt2({1'b1, 4'hF}, OP2_BICC, 22'h200000), 32'h0);
        send_word(mk_fmt2(5'd0, OP2_FBFCC, 22'h1FFFFF), 32'hFFFF_FFFF);
        send_word(mk_fmt2({1'b1, 4'h8}, OP2_CBCCC, 22'h3FFFFF), 32'h8000_0000);
        send_word({OP_CALL, 30'h3FFF_FFFF}, 32'h4);
        send_word({OP_CALL, 30'h2000_0000}, 32'hFFFF_FFFF);
        send_word(mk_fmt3(OP_ARITH, 5'd31, OP3_ADD, 5'd31, {1'b1, 13'h1000}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd1, OP3_ALU_HOLE, 5'd2, {1'b0, 13'h1FFF}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd3, OP3_SHIFT_LAST, 5'd4, {1'b1, 13'h001F}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd0, OP3_RDY, RS1_STBAR, 14'h0), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd9, OP3_RDTBR, 5'd0, 14'h0), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd0, OP3_WRY, 5'd1, {1'b1, 13'h0FFF}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd31, OP3_WRPSR, 5'd7, {1'b0, 13'd5}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd2, OP3_FPOP1, 5'd4, {OPF_3OP_LO, 5'd6}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd2, OP3_FPOP2, 5'd4, {OPF_3OP_Y, 5'd6}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd5, OP3_FPOP1, 5'd4, {OPF_UNLISTED, 5'd31}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd8, OP3_CPOP2, 5'd9, 14'h3FFF), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd15, OP3_TICC, 5'd3, {1'b1, 13'h1FFF}), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd0, OP3_RESTORE, 5'd0, 14'h0), $urandom());
        send_word(mk_fmt3(OP_ARITH, 5'd31, OP3_ARITH_SPARE, 5'd31, 14'h3FFF), $urandom());
        send_word(mk_fmt3(OP_MEM, 5'd1, OP3_LDA, 5'd2, {1'b0, 8'hFF, 5'd3}), $urandom());
        send_word(mk_fmt3(OP_MEM, 5'd1, OP3_STA, 5'd2, {1'b1, 13'h1ABC}), $urandom());
        send_word(mk_fmt3(OP_MEM, 5'd4, OP3_LDF, 5'd5, 14'h0), $urandom());
        send_word(mk_fmt3(OP_MEM, 5'd31, OP3_MEM_SPARE, 5'd31, 14'h3FFF), $urandom());
    endtask

    initial
    begin
        sid_result_t got;
        int          stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
                    stall_left = pick_gap();
            end
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.insn_class      = result_ch.insn_class;
                got.mnemonic_code   = result_ch.mnemonic_code;
                got.dest_reg        = result_ch.dest_reg;
                got.src1_reg        = result_ch.src1_reg;
                got.src2_reg        = result_ch.src2_reg;
                got.uses_immediate  = result_ch.uses_immediate;
                got.immediate_value = result_ch.immediate_value;
                got.target_address  = result_ch.target_address;
                got.annul_bit       = result_ch.annul_bit;
                got.space_id        = result_ch.space_id;
                got.sub_opcode      = result_ch.sub_opcode;
                got.recognized      = result_ch.recognized;
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        sb                  = new();
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        rx_stall_pct        = 0;
        long_hold_req       = 1'b0;
        instr_ch.valid      = 1'b0;
        instr_ch.instr_word = '0;
        instr_ch.pc         = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_swap(1'b0);
        run_directed();
        drain();

        set_swap(1'b1);
        run_random(500, 20, 20);
        drain();

        // The output side holds off while words keep coming, so the input backs up.
        long_hold_req = 1'b1;
        run_random(60, 0, 0);
        drain();

        set_swap(1'b0);
        run_random(700, 15, 25);
        drain();

        set_swap(1'b1);
        run_random(400, 0, 0);
        drain();

        set_swap(1'b0);
        run_random(400, 40, 40);
        drain();

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d decoded words never arrived", $time, sb.pending());
        end
        $display("Checked %0d decoded words in both byte orders, directed corner cases first,",
                 sb.checked);
        $display("then random words with gaps on both sides and one long output stall.");
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
